>>> src/assert_macros.svh
// Assertion helpers for the RTL files; only the datapath includes them.
// Each macro takes a label, the clock, the reset, a trigger and a property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QSP_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication.
`define QSP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> src/qsp_pkg.sv
// ----------------------------------------------------------------------------
// qsp_pkg
// Types, codes and default sizes of the shortest path engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qsp_pkg;

   // Default sizes.
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int MAX_EDGES_DEF    = 4096;
   localparam int QUEUE_DEPTH_DEF  = 1024;
   localparam int WEIGHT_BITS_DEF  = 16;

   // Configuration port shape and register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_VERTEX = 2'd1;
   localparam logic [10:0] VERTEX_COUNT_RESET = 11'd1024;

   // Item kinds.
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_RUN  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Controller states.
   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_DECODE,
      ST_ADD_RD_A, ST_ADD_WR_A, ST_ADD_RD_B, ST_ADD_WR_B,
      ST_READ_RD, ST_READ_CAP,
      ST_CLEAR, ST_SEED, ST_POP, ST_POP_CAP,
      ST_ARC_START, ST_ARC_RD, ST_ARC_NBR, ST_ARC_RELAX,
      ST_DONE
   } state_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_CLEAR_INIT, OP_CLEAR,
      OP_FLAG_RANGE, OP_FLAG_FULL,
      OP_ADD_RD_A, OP_ADD_WR_A, OP_ADD_RD_B, OP_ADD_WR_B,
      OP_READ_RD, OP_READ_CAP,
      OP_SEED, OP_POP, OP_POP_CAP,
      OP_ARC_START, OP_ARC_RD, OP_ARC_NBR, OP_ARC_RELAX,
      OP_FINISH
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type op;
      logic   in_ready;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       req_valid;
      logic [1:0] kind;
      logic       ends_ok;
      logic       room;
      logic       vertex_ok;
      logic       source_ok;
      logic       clear_last;
      logic       fill_zero;
      logic       len_zero;
      logic       count_last;
      logic       out_free;
   } stat_type;

endpackage

>>> src/qsp_channels.sv
// ----------------------------------------------------------------------------
// qsp_channels
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [9:0]  end_a;
   logic [9:0]  end_b;
   logic [15:0] weight;
   logic [9:0]  vertex;
   modport source (output valid, kind, end_a, end_b, weight, vertex, input ready);
   modport sink (input valid, kind, end_a, end_b, weight, vertex, output ready);
endinterface

interface qsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;
   logic [9:0]  predecessor;
   logic        has_predecessor;
   logic [1:0]  status;
   modport source (output valid, distance, predecessor, has_predecessor, status,
                   input ready);
   modport sink (input valid, distance, predecessor, has_predecessor, status,
                 output ready);
endinterface

interface qsp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/qsp_controller.sv
// ----------------------------------------------------------------------------
// qsp_controller
// Sequencer that steps the datapath through loads, reads and runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsp_controller
   import qsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.in_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.op = OP_CLEAR_INIT;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.kind)
               KIND_ADD: begin
                  if (!stat.ends_ok) begin
                     cmd.op   = OP_FLAG_RANGE;
                     state_in = ST_DONE;
                  end else if (!stat.room) begin
                     cmd.op   = OP_FLAG_FULL;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_ADD_RD_A;
                  end
               end
               KIND_RUN: state_in = ST_CLEAR;
               KIND_READ: begin
                  if (!stat.vertex_ok) begin
                     cmd.op   = OP_FLAG_RANGE;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_READ_RD;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_ADD_RD_A: begin
            cmd.op   = OP_ADD_RD_A;
            state_in = ST_ADD_WR_A;
         end
         ST_ADD_WR_A: begin
            cmd.op   = OP_ADD_WR_A;
            state_in = ST_ADD_RD_B;
         end
         ST_ADD_RD_B: begin
            cmd.op   = OP_ADD_RD_B;
            state_in = ST_ADD_WR_B;
         end
         ST_ADD_WR_B: begin
            cmd.op   = OP_ADD_WR_B;
            state_in = ST_DONE;
         end
         ST_READ_RD: begin
            cmd.op   = OP_READ_RD;
            state_in = ST_READ_CAP;
         end
         ST_READ_CAP: begin
            cmd.op   = OP_READ_CAP;
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) state_in = ST_SEED;
         end
         ST_SEED: begin
            if (stat.source_ok) begin
               cmd.op   = OP_SEED;
               state_in = ST_POP;
            end else begin
               cmd.op   = OP_FLAG_RANGE;
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            if (stat.fill_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_POP;
               state_in = ST_POP_CAP;
            end
         end
         ST_POP_CAP: begin
            cmd.op   = OP_POP_CAP;
            state_in = ST_ARC_START;
         end
         ST_ARC_START: begin
            cmd.op   = OP_ARC_START;
            state_in = stat.len_zero ? ST_POP : ST_ARC_RD;
         end
         ST_ARC_RD: begin
            cmd.op   = OP_ARC_RD;
            state_in = ST_ARC_NBR;
         end
         ST_ARC_NBR: begin
            cmd.op   = OP_ARC_NBR;
            state_in = ST_ARC_RELAX;
         end
         ST_ARC_RELAX: begin
            cmd.op   = OP_ARC_RELAX;
            state_in = stat.count_last ? ST_POP : ST_ARC_RD;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

endmodule

>>> src/qsp_datapath.sv
// ----------------------------------------------------------------------------
// qsp_datapath
// Graph storage, distance tables, work queue and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsp_datapath
   import qsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   qsp_req_if.sink  req,
   qsp_rsp_if.source rsp,
   qsp_csr_if.sink  csr,
   input  cmd_type  cmd,
   output stat_type stat
);

`include "assert_macros.svh"

   localparam int SLOTS = 2 * MAX_EDGES;
   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int NW    = $clog2(MAX_VERTICES + 1);
   localparam int XW    = (NW > 11) ? NW : 11;
   localparam int SW    = $clog2(SLOTS);
   localparam int UW    = $clog2(SLOTS + 1);
   localparam int LW    = UW;
   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int WB    = WEIGHT_BITS;
   localparam int AW    = VW + WB;

   // Memories.
   logic [AW-1:0] arc_mem   [SLOTS];
   logic [SW-1:0] link_mem  [SLOTS];
   logic [LW-1:0] len_mem   [MAX_VERTICES];
   logic [SW-1:0] first_mem [MAX_VERTICES];
   logic [SW-1:0] last_mem  [MAX_VERTICES];
   logic [31:0]   dist_mem  [MAX_VERTICES];
   logic [VW:0]   prev_mem  [MAX_VERTICES];
   logic          queued_mem[MAX_VERTICES];
   logic [VW-1:0] fifo_mem  [QUEUE_DEPTH];

   // Registered read data.
   logic [AW-1:0] arc_rd_ff;
   logic [SW-1:0] link_rd_ff, first_rd_ff, last_rd_ff;
   logic [LW-1:0] len_rd_ff;
   logic [31:0]   dist_rd_ff;
   logic [VW:0]   prev_rd_ff;
   logic          queued_rd_ff;
   logic [VW-1:0] fifo_rd_ff;

   // Control registers.
   logic [10:0]   vc_ff;
   logic [9:0]    src_ff;
   logic [UW-1:0] used_ff;
   logic [QW-1:0] head_ff, tail_ff;
   logic [FW-1:0] fill_ff;
   logic [VW-1:0] clr_ff;
   logic          rsp_valid_ff;

   // Item and walk registers.
   logic [1:0]    kind_ff;
   logic [XW-1:0] a_ff, b_ff, v_ff;
   logic [WB-1:0] w_ff;
   logic [VW-1:0] cur_ff, nx_ff;
   logic [LW-1:0] cnt_ff;
   logic [SW-1:0] slot_ff;
   logic [31:0]   d_ff, cand_ff;

   // Result being built and the response register.
   logic [31:0] res_dist_ff, out_dist_ff;
   logic [9:0]  res_pred_ff, out_pred_ff;
   logic        res_hp_ff, out_hp_ff;
   logic [1:0]  res_status_ff, out_status_ff;

   // Live vertex count and range checks.
   logic [XW-1:0] vc_x, n_live;
   logic          a_ok, b_ok, v_ok, s_ok, nx_ok, room;
   logic [31:0]   w_mask;
   logic [VW-1:0] a_idx, b_idx, v_idx, s_idx, arc_nbr;
   logic [WB-1:0] arc_w;
   logic [32:0]   sum;
   logic          improve, push;

   assign vc_x   = XW'(vc_ff);
   assign n_live = (vc_x == '0) ? XW'(1) :
                   (vc_x > XW'(MAX_VERTICES)) ? XW'(MAX_VERTICES) : vc_x;
   assign a_ok   = a_ff < n_live;
   assign b_ok   = b_ff < n_live;
   assign v_ok   = v_ff < n_live;
   assign s_ok   = XW'(src_ff) < n_live;
   assign nx_ok  = XW'(nx_ff) < n_live;
   assign room   = ({1'b0, used_ff} + (UW+1)'(2)) <= (UW+1)'(SLOTS);
   assign w_mask = 32'(req.weight) & ((32'd1 << WEIGHT_BITS) - 32'd1);
   assign a_idx  = a_ff[VW-1:0];
   assign b_idx  = b_ff[VW-1:0];
   assign v_idx  = v_ff[VW-1:0];
   assign s_idx  = VW'(src_ff);
   assign arc_nbr = arc_rd_ff[AW-1:WB];
   assign arc_w   = arc_rd_ff[WB-1:0];
   assign sum     = {1'b0, d_ff} + 33'(arc_w);

   // Relaxation decision for the arc under test.
   assign improve = (cmd.op == OP_ARC_RELAX) && nx_ok && (cand_ff < dist_rd_ff);
   assign push    = improve && !queued_rd_ff && (fill_ff < FW'(QUEUE_DEPTH));

   // Adjacency append: side A links a to b, side B links b to a.
   logic          add_wr, add_side_b;
   logic [VW-1:0] from_idx, to_idx;
   logic [SW-1:0] new_slot;
   logic          clearing;

   assign add_side_b = (cmd.op == OP_ADD_WR_B);
   assign add_wr     = (cmd.op == OP_ADD_WR_A) || add_side_b;
   assign from_idx   = add_side_b ? b_idx : a_idx;
   assign to_idx     = add_side_b ? a_idx : b_idx;
   assign new_slot   = add_side_b ? SW'(used_ff + UW'(1)) : used_ff[SW-1:0];
   assign clearing   = (cmd.op == OP_CLEAR) || (cmd.op == OP_CLEAR_INIT);

   // Edge store and links.
   always_ff @(posedge clock) begin
      if (add_wr) arc_mem[new_slot] <= {to_idx, w_ff};
      if (add_wr && (len_rd_ff != '0)) link_mem[last_rd_ff] <= new_slot;
      arc_rd_ff  <= arc_mem[slot_ff];
      link_rd_ff <= link_mem[slot_ff];
   end

   // Per-vertex list heads, tails and lengths.
   logic [VW-1:0] list_ra;
   always_comb begin
      case (cmd.op)
         OP_ADD_RD_A: list_ra = a_idx;
         OP_ADD_RD_B: list_ra = b_idx;
         default:     list_ra = fifo_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR_INIT) begin
         len_mem[clr_ff] <= '0;
      end else if (add_wr) begin
         len_mem[from_idx] <= LW'(len_rd_ff + LW'(1));
      end
      if (add_wr && (len_rd_ff == '0)) first_mem[from_idx] <= new_slot;
      if (add_wr) last_mem[from_idx] <= new_slot;
      len_rd_ff   <= len_mem[list_ra];
      first_rd_ff <= first_mem[list_ra];
      last_rd_ff  <= last_mem[list_ra];
   end

   // Distances, predecessors and queued marks.
   logic [VW-1:0] dist_ra;
   always_comb begin
      case (cmd.op)
         OP_READ_RD: dist_ra = v_idx;
         OP_ARC_NBR: dist_ra = arc_nbr;
         default:    dist_ra = fifo_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         dist_mem[clr_ff]   <= '1;
         prev_mem[clr_ff]   <= '0;
         queued_mem[clr_ff] <= 1'b0;
      end else if (cmd.op == OP_SEED) begin
         dist_mem[s_idx]   <= '0;
         queued_mem[s_idx] <= 1'b1;
      end else if (cmd.op == OP_POP_CAP) begin
         queued_mem[fifo_rd_ff] <= 1'b0;
      end else if (improve) begin
         dist_mem[nx_ff] <= cand_ff;
         prev_mem[nx_ff] <= {1'b1, cur_ff};
         if (push) queued_mem[nx_ff] <= 1'b1;
      end
      dist_rd_ff   <= dist_mem[dist_ra];
      prev_rd_ff   <= prev_mem[v_idx];
      queued_rd_ff <= queued_mem[arc_nbr];
   end

   // Work queue storage.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_SEED) begin
         fifo_mem[tail_ff] <= s_idx;
      end else if (push) begin
         fifo_mem[tail_ff] <= nx_ff;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   // Control registers: configuration, counters, pointers, response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= VERTEX_COUNT_RESET;
         src_ff       <= '0;
         used_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            if (csr.index == CSR_VERTEX_COUNT) vc_ff <= csr.data[10:0];
            else if (csr.index == CSR_SOURCE_VERTEX) src_ff <= csr.data[9:0];
         end
         if (clearing) begin
            clr_ff  <= (clr_ff == VW'(MAX_VERTICES - 1)) ? '0 : clr_ff + VW'(1);
            head_ff <= '0;
            tail_ff <= '0;
            fill_ff <= '0;
         end
         if (cmd.op == OP_ADD_WR_B) used_ff <= used_ff + UW'(2);
         if ((cmd.op == OP_SEED) || push) begin
            tail_ff <= (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QW'(1);
            fill_ff <= fill_ff + FW'(1);
         end
         if (cmd.op == OP_POP) begin
            head_ff <= (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
            fill_ff <= fill_ff - FW'(1);
         end
         if (cmd.op == OP_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Item capture, list walk and result building.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            kind_ff       <= req.kind;
            a_ff          <= XW'(req.end_a);
            b_ff          <= XW'(req.end_b);
            v_ff          <= XW'(req.vertex);
            w_ff          <= w_mask[WB-1:0];
            res_dist_ff   <= '0;
            res_pred_ff   <= '0;
            res_hp_ff     <= 1'b0;
            res_status_ff <= STATUS_OK;
         end
         OP_FLAG_RANGE: res_status_ff <= STATUS_RANGE;
         OP_FLAG_FULL:  res_status_ff <= STATUS_FULL;
         OP_READ_CAP: begin
            res_dist_ff <= dist_rd_ff;
            if (prev_rd_ff[VW]) begin
               res_pred_ff <= 10'(prev_rd_ff[VW-1:0]);
               res_hp_ff   <= 1'b1;
            end
         end
         OP_POP_CAP: cur_ff <= fifo_rd_ff;
         OP_ARC_START: begin
            cnt_ff  <= len_rd_ff;
            slot_ff <= first_rd_ff;
            d_ff    <= dist_rd_ff;
         end
         OP_ARC_NBR: begin
            nx_ff   <= arc_nbr;
            cand_ff <= sum[32] ? '1 : sum[31:0];
            slot_ff <= link_rd_ff;
         end
         OP_ARC_RELAX: cnt_ff <= cnt_ff - LW'(1);
         OP_FINISH: begin
            out_dist_ff   <= res_dist_ff;
            out_pred_ff   <= res_pred_ff;
            out_hp_ff     <= res_hp_ff;
            out_status_ff <= res_status_ff;
         end
         default: begin
         end
      endcase
   end

   // Channel outputs.
   assign req.ready           = cmd.in_ready;
   assign csr.ready           = 1'b1;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.distance        = out_dist_ff;
   assign rsp.predecessor     = out_pred_ff;
   assign rsp.has_predecessor = out_hp_ff;
   assign rsp.status          = out_status_ff;

   // Status to the controller.
   assign stat.req_valid  = req.valid;
   assign stat.kind       = kind_ff;
   assign stat.ends_ok    = a_ok && b_ok;
   assign stat.room       = room;
   assign stat.vertex_ok  = v_ok;
   assign stat.source_ok  = s_ok;
   assign stat.clear_last = (clr_ff == VW'(MAX_VERTICES - 1));
   assign stat.fill_zero  = (fill_ff == '0);
   assign stat.len_zero   = (len_rd_ff == '0);
   assign stat.count_last = (cnt_ff == LW'(1));
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

   // Checks on the controller and datapath working together.
   `QSP_ASSERT_IMPLY(a_pop_nonempty, clock, reset, cmd.op == OP_POP, fill_ff != '0)
   `QSP_ASSERT_IMPLY(a_add_room, clock, reset, cmd.op == OP_ADD_RD_A, room && a_ok && b_ok)
   `QSP_ASSERT_IMPLY(a_finish_free, clock, reset, cmd.op == OP_FINISH, !rsp_valid_ff || rsp.ready)
   `QSP_ASSERT_NEXT(a_used_bound, clock, reset, cmd.op == OP_ADD_WR_B, used_ff <= UW'(SLOTS))

endmodule

>>> src/queue_shortest_path_engine_top.sv
// ----------------------------------------------------------------------------
// queue_shortest_path_engine_top
// Queue-based single-source shortest path engine over a loaded graph.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer over tables with registered reads.
// An edge load makes two read and write pairs on the adjacency tables, and a read
// makes one table read. A run first clears the distance tables, then takes each
// vertex from the work queue and walks its arcs; each arc needs an edge table read,
// a distance read and a compare with write-back.
// After reset the block clears all MAX_VERTICES entries (1024 by default) of its
// per-vertex tables and takes no request in that time; register writes are accepted
// throughout. A response waits in its own register, so the next request is taken
// while the previous response is still pending.
`timescale 1ns / 1ps

module queue_shortest_path_engine_top
   import qsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)
(
   input logic       clock,
   input logic       reset,
   qsp_req_if.sink   req,
   qsp_rsp_if.source rsp,
   qsp_csr_if.sink   csr
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   qsp_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Storage and arithmetic.
   qsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the queue-based shortest path engine.
// Graphs are loaded edge by edge, then runs and vertex reads go in under
// several vertex counts and sources. A built-in path solver predicts every
// response, and the monitor compares each response with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import qsp_pkg::*;

   localparam int  ARC_SLOTS  = 2 * MAX_EDGES_DEF;
   localparam int  CYCLE_CAP  = 4000000;
   localparam logic [31:0] NO_PATH = 32'hFFFF_FFFF;

   typedef struct {
      logic [1:0]  kind;
      logic [9:0]  end_a;
      logic [9:0]  end_b;
      logic [15:0] weight;
      logic [9:0]  vertex;
   } graph_op_t;

   typedef struct {
      logic [31:0] distance;
      logic [9:0]  predecessor;
      logic        has_predecessor;
      logic [1:0]  status;
   } path_answer_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qsp_req_if req ();
   qsp_rsp_if rsp ();
   qsp_csr_if csr ();

   queue_shortest_path_engine_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #4 clock = ~clock;

   // Shadow copy of the engine's graph and path tables.
   int unsigned arc_next [ARC_SLOTS];
   int unsigned arc_to   [ARC_SLOTS];
   int unsigned arc_wt   [ARC_SLOTS];
   int unsigned arcs_used;
   int unsigned adj_len   [MAX_VERTICES_DEF];
   int unsigned adj_first [MAX_VERTICES_DEF];
   int unsigned adj_last  [MAX_VERTICES_DEF];
   logic [31:0] dist_tab  [MAX_VERTICES_DEF];
   int unsigned prev_tab  [MAX_VERTICES_DEF];
   bit          prev_ok   [MAX_VERTICES_DEF];
   bit          in_work   [MAX_VERTICES_DEF];
   int unsigned work_list [$];
   int unsigned shadow_count = 1024;
   int unsigned shadow_source = 0;

   graph_op_t    pending_ops [$];
   path_answer_t expected_answers [$];
   graph_op_t    offer;
   int           burst_left = 1;
   int           gap_left = 0;
   int           ops_accepted = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   bit           stall_done = 1'b0;
   int           ready_mode = 0;
   int           mode_left = 0;

   function automatic int unsigned live_vertices();
      if (shadow_count == 0) return 1;
      if (shadow_count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
      return shadow_count;
   endfunction

   function automatic void link_arc(int unsigned from, int unsigned to, int unsigned w);
      arc_next[arcs_used] = 0;
      arc_to[arcs_used]   = to;
      arc_wt[arcs_used]   = w;
      if (adj_len[from] == 0) adj_first[from] = arcs_used;
      else arc_next[adj_last[from]] = arcs_used;
      adj_last[from] = arcs_used;
      adj_len[from]++;
      arcs_used++;
   endfunction

   function automatic void enqueue_vertex(int unsigned v);
      if (in_work[v] || work_list.size() >= QUEUE_DEPTH_DEF) return;
      work_list.push_back(v);
      in_work[v] = 1'b1;
   endfunction

   // Queue-based relaxation from the current source.
   function automatic logic [1:0] solve_paths();
      int unsigned n, cur, slot, nx;
      logic [32:0] cand;
      n = live_vertices();
      for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
         in_work[i] = 1'b0; prev_ok[i] = 1'b0; prev_tab[i] = 0; dist_tab[i] = NO_PATH;
      end
      work_list.delete();
      if (shadow_source >= n) return STATUS_RANGE;
      dist_tab[shadow_source] = 32'd0;
      enqueue_vertex(shadow_source);
      while (work_list.size() != 0) begin
         cur = work_list.pop_front();
         in_work[cur] = 1'b0;
         slot = adj_first[cur];
         for (int k = 0; k < adj_len[cur]; k++) begin
            nx = arc_to[slot % ARC_SLOTS];
            cand = {1'b0, dist_tab[cur]} + arc_wt[slot % ARC_SLOTS];
            if (cand[32]) cand = {1'b0, NO_PATH};
            if (nx < n && cand[31:0] < dist_tab[nx]) begin
               dist_tab[nx] = cand[31:0];
               prev_tab[nx] = cur;
               prev_ok[nx]  = 1'b1;
               enqueue_vertex(nx);
            end
            slot = arc_next[slot % ARC_SLOTS];
         end
      end
      return STATUS_OK;
   endfunction

   function automatic path_answer_t predict_answer(graph_op_t op);
      path_answer_t ans;
      int unsigned n;
      n = live_vertices();
      ans = '{32'd0, 10'd0, 1'b0, STATUS_OK};
      case (op.kind)
         KIND_ADD: begin
            if (op.end_a >= n || op.end_b >= n) ans.status = STATUS_RANGE;
            else if (arcs_used + 2 > ARC_SLOTS) ans.status = STATUS_FULL;
            else begin
               link_arc(op.end_a, op.end_b, op.weight);
               link_arc(op.end_b, op.end_a, op.weight);
            end
         end
         KIND_RUN: ans.status = solve_paths();
         KIND_READ: begin
            if (op.vertex >= n) ans.status = STATUS_RANGE;
            else begin
               ans.distance = dist_tab[op.vertex];
               if (prev_ok[op.vertex]) begin
                  ans.predecessor = prev_tab[op.vertex][9:0];
                  ans.has_predecessor = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Stimulus builders.
   function automatic void queue_op(logic [1:0] k, int unsigned a, int unsigned b,
                                    int unsigned w, int unsigned v);
      graph_op_t op;
      op.kind = k; op.end_a = a[9:0]; op.end_b = b[9:0];
      op.weight = w[15:0]; op.vertex = v[9:0];
      pending_ops.push_back(op);
   endfunction

   function automatic void queue_add(int unsigned a, int unsigned b, int unsigned w);
      queue_op(KIND_ADD, a, b, w, $urandom_range(0, 1023));
   endfunction

   function automatic void queue_run();
      queue_op(KIND_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 65535), $urandom_range(0, 1023));
   endfunction

   function automatic void queue_read(int unsigned v);
      queue_op(KIND_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 65535), v);
   endfunction

   // Mostly in-range adds and reads with occasional runs, noise and bad indexes.
   function automatic void queue_random_mix(int count, int unsigned n);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 42)
            queue_add($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                      $urandom_range(0, 65535));
         else if (pick < 47) queue_run();
         else if (pick < 87) queue_read($urandom_range(0, n - 1));
         else if (pick < 91)
            queue_op(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 65535), $urandom_range(0, 1023));
         else if (pick < 96)
            queue_add($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 65535));
         else queue_read($urandom_range(0, 1023));
      end
   endfunction

   task automatic write_register(logic [1:0] index, logic [15:0] data);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   // Waits until every queued transaction has been answered and the block is idle.
   task automatic drain();
      while (pending_ops.size() != 0 || req.valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register shadow follows accepted write transactions.
   always @(posedge clock) begin
      if (!reset && csr.valid && csr.ready) begin
         if (csr.index == CSR_VERTEX_COUNT) shadow_count = csr.data[10:0];
         else if (csr.index == CSR_SOURCE_VERTEX) shadow_source = csr.data[9:0];
      end
   end

   // Request driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_answers.push_back(predict_answer(offer));
            ops_accepted++;
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               offer = pending_ops.pop_front();
               req.valid  <= 1'b1;
               req.kind   <= offer.kind;
               req.end_a  <= offer.end_a;
               req.end_b  <= offer.end_b;
               req.weight <= offer.weight;
               req.vertex <= offer.vertex;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: a changing stall pattern plus one long hold-off.
   always @(posedge clock) begin
      if (!stall_done && ops_accepted >= 150) begin
         stall_done = 1'b1;
         stall_left = 400;
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 1) == 0);
            default: rsp.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      path_answer_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
         end else begin
            want = expected_answers.pop_front();
            if (rsp.distance !== want.distance || rsp.predecessor !== want.predecessor ||
                rsp.has_predecessor !== want.has_predecessor ||
                rsp.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected dist %h pred %0d has %b status %0d, ",
                            "got dist %h pred %0d has %b status %0d"},
                           want.distance, want.predecessor, want.has_predecessor,
                           want.status, rsp.distance, rsp.predecessor,
                           rsp.has_predecessor, rsp.status);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0; req.kind = 2'd0; req.end_a = 10'd0; req.end_b = 10'd0;
      req.weight = 16'd0; req.vertex = 10'd0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = 2'd0; csr.data = 16'd0;
      for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
         adj_len[i] = 0; dist_tab[i] = NO_PATH; prev_ok[i] = 1'b0; prev_tab[i] = 0;
         in_work[i] = 1'b0; adj_first[i] = 0; adj_last[i] = 0;
      end
      arcs_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Small graph: extreme weights, self loop, endpoint and read range checks.
      write_register(CSR_VERTEX_COUNT, 16'd16);
      write_register(CSR_SOURCE_VERTEX, 16'd0);
      queue_read(5);
      queue_add(0, 1, 65535);
      queue_add(1, 2, 0);
      queue_add(2, 3, 7);
      queue_add(3, 3, 5);
      queue_add(0, 16, 1);
      queue_add(16, 0, 1);
      queue_add(0, 15, 65535);
      queue_add(15, 3, 1);
      queue_run();
      for (int v = 0; v < 4; v++) queue_read(v);
      queue_read(15);
      queue_read(16);
      queue_read(1023);
      queue_op(2'd3, 1023, 1023, 65535, 1023);
      drain();

      // Source outside the vertex range.
      write_register(CSR_SOURCE_VERTEX, 16'd20);
      queue_run();
      queue_read(0);
      drain();
      write_register(CSR_SOURCE_VERTEX, 16'd3);
      queue_random_mix(220, 16);
      drain();

      // Zero vertex count behaves as one vertex.
      write_register(CSR_VERTEX_COUNT, 16'd0);
      write_register(CSR_SOURCE_VERTEX, 16'd0);
      queue_run();
      queue_read(0);
      queue_read(1);
      queue_add(0, 0, 9);
      queue_add(0, 1, 9);
      drain();

      // Oversized count clamps to the full vertex range.
      write_register(CSR_VERTEX_COUNT, 16'hFFFF);
      write_register(CSR_SOURCE_VERTEX, 16'd1023);
      queue_add(1023, 0, 12);
      queue_add(0, 1023, 3);
      queue_random_mix(250, 1024);
      queue_run();
      drain();

      // Lowered count: neighbors above it are skipped.
      write_register(CSR_VERTEX_COUNT, 16'd8);
      write_register(CSR_SOURCE_VERTEX, 16'd1);
      queue_run();
      queue_random_mix(150, 8);
      drain();

      // Long chain from the source, then reads along it.
      write_register(CSR_VERTEX_COUNT, 16'd1024);
      write_register(CSR_SOURCE_VERTEX, 16'd100);
      for (int i = 0; i < 80; i++) begin
         int unsigned a;
         a = 100 + i;
         queue_add(a, a + 1, $urandom_range(0, 65535));
      end
      queue_run();
      for (int i = 0; i < 20; i++) queue_read($urandom_range(90, 190));
      queue_add(5, 6, 1);
      drain();
      repeat (50) @(posedge clock);

      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
